>>> hw/rtl/upd_pkg.sv
// shared types, character codes and decode helpers for the url percent decoder
package upd_pkg;

  localparam logic [7:0] CharPlus     = 8'h2B;
  localparam logic [7:0] CharPercent  = 8'h25;
  localparam logic [7:0] CharQuestion = 8'h3F;
  localparam logic [7:0] CharSpace    = 8'h20;

  localparam int unsigned JobFifoDepthDef = 4;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            fin;
  } job_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h57;
    end
    hex_val = v[3:0];
  endfunction

  function automatic logic [7:0] plain_map(input logic [7:0] c);
    plain_map = (c == CharPlus) ? CharSpace : c;
  endfunction

endpackage

>>> hw/rtl/upd_front.sv
// front end: takes encoded bytes, tracks open escapes and builds result jobs
module upd_front import upd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_final_i,
  output logic       job_valid_o,
  output job_t       job_o
);

  logic            open_q, open_d;
  logic            cnt_q, cnt_d;
  logic [7:0]      held_q, held_d;
  logic [2:0][7:0] res;
  logic [1:0]      n;

  always_comb begin
    res    = '0;
    n      = 2'd0;
    open_d = open_q;
    cnt_d  = cnt_q;
    held_d = held_q;
    if (!open_q) begin
      if (in_byte_i == CharPercent) begin
        open_d = 1'b1;
        cnt_d  = 1'b0;
      end else begin
        res[0] = plain_map(in_byte_i);
        n      = 2'd1;
      end
    end else if (!cnt_q) begin
      cnt_d  = 1'b1;
      held_d = in_byte_i;
    end else if (is_hex(held_q) && is_hex(in_byte_i)) begin
      res[0] = {hex_val(held_q), hex_val(in_byte_i)};
      n      = 2'd1;
      open_d = 1'b0;
      cnt_d  = 1'b0;
    end else begin
      res[0] = CharQuestion;
      n      = 2'd1;
      if (held_q == CharPercent) begin
        open_d = 1'b1;
        cnt_d  = 1'b1;
        held_d = in_byte_i;
      end else begin
        res[1] = plain_map(held_q);
        n      = 2'd2;
        if (in_byte_i == CharPercent) begin
          open_d = 1'b1;
          cnt_d  = 1'b0;
        end else begin
          res[2] = plain_map(in_byte_i);
          n      = 2'd3;
          open_d = 1'b0;
          cnt_d  = 1'b0;
        end
      end
    end
    // flush at end of string
    if (in_final_i && open_d) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) == n) begin
          res[k] = CharQuestion;
        end
        if (cnt_d && 2'(k) == n + 2'd1) begin
          res[k] = (held_d == CharPercent) ? CharQuestion : plain_map(held_d);
        end
      end
      n      = n + (cnt_d ? 2'd2 : 2'd1);
      open_d = 1'b0;
      cnt_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      cnt_q  <= 1'b0;
    end else if (accept_i) begin
      open_q <= open_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

  assign job_valid_o = accept_i && (n != 2'd0);
  assign job_o       = '{bytes: res, cnt: n, fin: in_final_i};

  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> job_o.cnt != 2'd0) else $error("empty job pushed");

  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && in_final_i) |=> !open_q) else $error("escape left open after final byte");

  a_final_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && in_final_i) |-> job_valid_o) else $error("final byte gave no result");

endmodule

>>> hw/rtl/upd_job_fifo.sv
// short job queue between front and back end
module upd_job_fifo import upd_pkg::*; #(
  parameter int unsigned Depth = JobFifoDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full job queue");

endmodule

>>> hw/rtl/upd_back.sv
// back end: unpacks jobs into single result bytes on the result ports
module upd_back import upd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       string_end_o
);

  logic [1:0]      rem_q;
  logic [2:0][7:0] bytes_q;
  logic            fin_q;
  logic            take, advance;

  assign empty_o   = (rem_q == 2'd0);
  assign take      = empty_o || (pop_i && rem_q == 2'd1);
  assign advance   = pop_i && (rem_q > 2'd1);
  assign job_pop_o = take && job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
    end else if (take) begin
      rem_q <= job_valid_i ? job_i.cnt : 2'd0;
    end else if (advance) begin
      rem_q <= rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      bytes_q <= job_i.bytes;
      fin_q   <= job_i.fin;
    end else if (advance) begin
      bytes_q <= {8'h00, bytes_q[2:1]};
    end
  end

  assign out_byte_o   = bytes_q[0];
  assign run_end_o    = (rem_q == 2'd1);
  assign string_end_o = (rem_q == 2'd1) && fin_q;

  a_string_end_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    string_end_o |-> run_end_o && !empty_o) else $error("string end off a run end");

endmodule

>>> hw/rtl/url_percent_decoder_unit.sv
// top level of the url percent decoder
//
// input channel: push with in_byte_i / in_final_i; a request is taken when
// push is high and full is low. in_final_i marks the last byte of a string.
// result channel: while empty is low the oldest decoded byte is on
// out_byte_o, run_end_o and string_end_o; pop with empty low takes it.
// an input byte gives zero to three results; run_end_o flags the last one
// of a request and string_end_o the last one of a string.
// the first result of a request passes through the job queue and the
// output stage registers before it is on the result ports.
// throughput: one request per cycle while full is low; the result side
// moves one byte per cycle while pop is high, so results leave one per pop.
// the front end classifies each byte combinationally and, when it gives
// results, writes a job into a queue of JobFifoDepth entries; full rises only
// when that queue is full. when the receiver stalls the result holds and
// requests keep flowing into the queue until it fills.
// reset clears the open escape, the queue and the output stage.
module url_percent_decoder_unit import upd_pkg::*; #(
  parameter int unsigned JobFifoDepth = JobFifoDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_final_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       string_end_o
);

  logic accept;
  logic front_valid;
  job_t front_job;
  logic q_valid;
  job_t q_job;
  logic q_pop;

  assign accept = push && !full;

  upd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .in_final_i  (in_final_i),
    .job_valid_o (front_valid),
    .job_o       (front_job)
  );

  upd_job_fifo #(
    .Depth (JobFifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_job),
    .full_o      (full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_job)
  );

  upd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_valid),
    .job_i        (q_job),
    .job_pop_o    (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .string_end_o (string_end_o)
  );

endmodule
